### sv/iyrc_pkg.sv
package iyrc_pkg;

  // CORDIC iteration count and tick counter width
  localparam int ANGLE_BITS = 16;
  localparam int TIMER_BITS = 16;
  localparam int ITER_W     = $clog2(ANGLE_BITS);

  // Field widths
  localparam int QUAT_W     = 16;
  localparam int HEAD_W     = 16;
  localparam int RATE_W     = 16;
  localparam int SPEED_W    = 15;
  localparam int LIMIT_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Datapath widths: CORDIC vector components and 32-bit angle accumulator
  localparam int CORDIC_W   = 36;
  localparam int PROD_W     = 2 * QUAT_W;
  localparam int ACC_W      = 32;
  localparam int TMR_CMP_W  = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;

  // Input opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DRIVE   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_REACHED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ROT_TO  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_INIT_TO = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_DELTA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_TIMEOUT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_TIMEOUT = 3'd5;

  // Register reset values
  localparam logic signed [HEAD_W-1:0] RST_TARGET_DELTA = 16'sh8000;
  localparam logic [SPEED_W-1:0]       RST_TOLERANCE    = 15'd209;
  localparam logic [SPEED_W-1:0]       RST_MAX_SPEED    = 15'd3277;
  localparam logic [SPEED_W-1:0]       RST_MIN_SPEED    = 15'd3277;
  localparam logic [LIMIT_W-1:0]       RST_ROT_TIMEOUT  = 16'd200;
  localparam logic [LIMIT_W-1:0]       RST_INIT_TIMEOUT = 16'd30;

  typedef struct packed {
    logic signed [HEAD_W-1:0] target_delta;
    logic [SPEED_W-1:0]       tolerance;
    logic [SPEED_W-1:0]       max_speed;
    logic [SPEED_W-1:0]       min_speed;
    logic [LIMIT_W-1:0]       rotate_timeout;
    logic [LIMIT_W-1:0]       init_timeout;
  } iyrc_cfg_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [ACC_W-1:0] atan_lut(input logic [4:0] idx);
    logic [ACC_W-1:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### sv/iyrc_if.sv
// Input item channel: IMU sample or control tick
interface iyrc_in_if import iyrc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [QUAT_W-1:0] quat_x;
  logic signed [QUAT_W-1:0] quat_y;
  logic signed [QUAT_W-1:0] quat_z;
  logic signed [QUAT_W-1:0] quat_w;

  modport source (output valid, output opcode, output quat_x, output quat_y,
                  output quat_z, output quat_w, input ready);
  modport sink (input valid, input opcode, input quat_x, input quat_y,
                input quat_z, input quat_w, output ready);
endinterface

// Result channel: rate command and status
interface iyrc_out_if import iyrc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] angular_rate;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output angular_rate, output status, input ready);
  modport sink (input valid, input angular_rate, input status, output ready);
endinterface

// Register write channel
interface iyrc_cfg_if import iyrc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/iyrc_regs.sv
module iyrc_regs import iyrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  iyrc_cfg_if.sink   cfg_i,
  output iyrc_cfg_t  cfg_o
);

  iyrc_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode a write transfer; ignore unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_TARGET_DELTA: cfg_d.target_delta   = signed'(cfg_i.data);
        REG_TOLERANCE:    cfg_d.tolerance      = cfg_i.data[SPEED_W-1:0];
        REG_MAX_SPEED:    cfg_d.max_speed      = cfg_i.data[SPEED_W-1:0];
        REG_MIN_SPEED:    cfg_d.min_speed      = cfg_i.data[SPEED_W-1:0];
        REG_ROT_TIMEOUT:  cfg_d.rotate_timeout = cfg_i.data[LIMIT_W-1:0];
        REG_INIT_TIMEOUT: cfg_d.init_timeout   = cfg_i.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_delta   <= RST_TARGET_DELTA;
      cfg_q.tolerance      <= RST_TOLERANCE;
      cfg_q.max_speed      <= RST_MAX_SPEED;
      cfg_q.min_speed      <= RST_MIN_SPEED;
      cfg_q.rotate_timeout <= RST_ROT_TIMEOUT;
      cfg_q.init_timeout   <= RST_INIT_TIMEOUT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### sv/iyrc_yaw.sv
module iyrc_yaw import iyrc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [QUAT_W-1:0] quat_x_i,
  input  logic signed [QUAT_W-1:0] quat_y_i,
  input  logic signed [QUAT_W-1:0] quat_z_i,
  input  logic signed [QUAT_W-1:0] quat_w_i,
  output logic                     done_o,
  output logic [HEAD_W-1:0]        heading_o
);

  localparam logic [2:0] Y_IDLE  = 3'd0;
  localparam logic [2:0] Y_MUL   = 3'd1;
  localparam logic [2:0] Y_FORM  = 3'd2;
  localparam logic [2:0] Y_PREP  = 3'd3;
  localparam logic [2:0] Y_ITER  = 3'd4;
  localparam logic [2:0] Y_ROUND = 3'd5;

  localparam logic [1:0] M_WZ = 2'd0;
  localparam logic [1:0] M_XY = 2'd1;
  localparam logic [1:0] M_YY = 2'd2;
  localparam logic [1:0] M_ZZ = 2'd3;

  localparam logic [ITER_W-1:0]          IT_LAST = ITER_W'(ANGLE_BITS - 1);
  localparam logic signed [CORDIC_W-1:0] X_ONE   = CORDIC_W'(1 << 30);
  localparam logic [ACC_W-1:0]           ANG_PI  = 32'h8000_0000;
  localparam logic [ACC_W-1:0]           ANG_RND = 32'h0000_8000;

  logic [2:0]                st_q, st_d;
  logic [1:0]                mcnt_q, mcnt_d;
  logic [ITER_W-1:0]         it_q, it_d;
  logic signed [QUAT_W-1:0]  qx_q, qx_d, qy_q, qy_d, qz_q, qz_d, qw_q, qw_d;
  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d;
  logic [ACC_W-1:0]          ang_q, ang_d;
  logic                      done_q, done_d;
  logic [HEAD_W-1:0]         head_q, head_d;

  logic signed [QUAT_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [CORDIC_W-1:0] prod_ext, xs, ys;
  logic [ACC_W-1:0]           tab, rnd;
  logic                       y_pos;

  // Shared multiplier: one product of the quaternion terms per cycle
  always_comb begin
    case (mcnt_q)
      M_WZ:    begin op_a = qw_q; op_b = qz_q; end
      M_XY:    begin op_a = qx_q; op_b = qy_q; end
      M_YY:    begin op_a = qy_q; op_b = qy_q; end
      default: begin op_a = qz_q; op_b = qz_q; end
    endcase
  end

  assign prod     = op_a * op_b;
  assign prod_ext = {{(CORDIC_W - PROD_W){prod[PROD_W-1]}}, prod};

  // Shared CORDIC rotation step
  assign xs    = x_q >>> it_q;
  assign ys    = y_q >>> it_q;
  assign y_pos = !y_q[CORDIC_W-1] && (y_q != '0);
  assign tab   = atan_lut(5'(it_q));
  assign rnd   = ang_q + ANG_RND;

  // Sequencer: multiply, form vector, fold to right half plane, rotate, round (a zero vector skips the rotation)
  always_comb begin
    st_d   = st_q;
    mcnt_d = mcnt_q;
    it_d   = it_q;
    qx_d   = qx_q;
    qy_d   = qy_q;
    qz_d   = qz_q;
    qw_d   = qw_q;
    x_d    = x_q;
    y_d    = y_q;
    ang_d  = ang_q;
    head_d = head_q;
    done_d = 1'b0;
    case (st_q)
      Y_IDLE: begin
        if (start_i) begin
          qx_d   = quat_x_i;
          qy_d   = quat_y_i;
          qz_d   = quat_z_i;
          qw_d   = quat_w_i;
          mcnt_d = M_WZ;
          st_d   = Y_MUL;
        end
      end
      Y_MUL: begin
        mcnt_d = mcnt_q + 2'd1;
        case (mcnt_q)
          M_WZ: y_d = prod_ext;
          M_XY: y_d = y_q + prod_ext;
          M_YY: x_d = prod_ext;
          default: begin
            x_d  = x_q + prod_ext;
            st_d = Y_FORM;
          end
        endcase
      end
      Y_FORM: begin
        y_d  = y_q <<< 1;
        x_d  = X_ONE - (x_q <<< 1);
        st_d = Y_PREP;
      end
      Y_PREP: begin
        it_d = '0;
        if (x_q == '0 && y_q == '0) begin
          // Zero vector: heading is zero
          ang_d = '0;
          st_d  = Y_ROUND;
        end else if (x_q[CORDIC_W-1]) begin
          x_d   = -x_q;
          y_d   = -y_q;
          ang_d = ANG_PI;
          st_d  = Y_ITER;
        end else begin
          ang_d = '0;
          st_d  = Y_ITER;
        end
      end
      Y_ITER: begin
        if (y_pos) begin
          x_d   = x_q + ys;
          y_d   = y_q - xs;
          ang_d = ang_q + tab;
        end else begin
          x_d   = x_q - ys;
          y_d   = y_q + xs;
          ang_d = ang_q - tab;
        end
        it_d = it_q + ITER_W'(1);
        if (it_q == IT_LAST) begin
          st_d = Y_ROUND;
        end
      end
      Y_ROUND: begin
        head_d = rnd[ACC_W-1:ACC_W-HEAD_W];
        done_d = 1'b1;
        st_d   = Y_IDLE;
      end
      default: st_d = Y_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= Y_IDLE;
      mcnt_q <= M_WZ;
      it_q   <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      mcnt_q <= mcnt_d;
      it_q   <= it_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q   <= qx_d;
    qy_q   <= qy_d;
    qz_q   <= qz_d;
    qw_q   <= qw_d;
    x_q    <= x_d;
    y_q    <= y_d;
    ang_q  <= ang_d;
    head_q <= head_d;
  end

  assign done_o    = done_q;
  assign heading_o = head_q;

  // Last rotation step always hands over to rounding
  a_iter_to_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == Y_ITER && it_q == IT_LAST) |=> (st_q == Y_ROUND))
    else $error("CORDIC did not round after last step");

endmodule

### sv/imu_yaw_rotation_controller.sv
// Proportional yaw rotation controller.
// in_i carries IMU orientation samples (opcode sample, Q1.15 quaternion) and
// control ticks (opcode tick). out_o carries one result per tick that needs
// one: a drive rate or a single stop with its status. cfg_i writes the six
// registers by index; write only while the block is idle.
// A sample holds in_i.ready low from its transfer until its heading is in: the
// iterative CORDIC forms the products on the shared multiplier, forms and
// folds the vector, runs ANGLE_BITS rotation steps (none for a zero vector)
// and rounds, then the headings are updated. Samples give no result.
// A tick that drives or arrives steps through timer and error, clamp and
// output load; its result becomes valid in the output register in the same
// cycle that the block is ready for the next item.
// A timeout stop skips the clamp; a tick with no result goes straight back
// to idle. No item is taken while busy.
// The output register holds a result until it is taken; the next item is
// accepted meanwhile, and a later tick waits in its last cycle only while
// the register is still full.
// Reset restores the register defaults, clears the headings and the tick
// count and waits for the first sample.
module imu_yaw_rotation_controller import iyrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  iyrc_in_if.sink     in_i,
  iyrc_out_if.source  out_o,
  iyrc_cfg_if.sink    cfg_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_YAW  = 3'd1;
  localparam logic [2:0] ST_TICK = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam logic [1:0] PH_WAIT   = 2'd0;
  localparam logic [1:0] PH_ROTATE = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  iyrc_cfg_t cfg;

  logic [2:0]                st_q, st_d;
  logic [1:0]                phase_q, phase_d;
  logic [HEAD_W-1:0]         cur_q, cur_d, goal_q, goal_d;
  logic [TIMER_BITS-1:0]     tick_q, tick_d;
  logic [HEAD_W-1:0]         mag_q, mag_d;
  logic                      neg_q, neg_d;
  logic signed [RATE_W-1:0]  res_rate_q, res_rate_d;
  logic [STATUS_W-1:0]       res_status_q, res_status_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [RATE_W-1:0]  out_rate_q, out_rate_d;
  logic [STATUS_W-1:0]       out_status_q, out_status_d;

  logic                  in_ready, in_fire, yaw_start, yaw_done, out_free;
  logic [HEAD_W-1:0]     yaw_heading, diff, diff_mag;
  logic                  diff_neg, over, reached;
  logic [LIMIT_W-1:0]    limit;
  logic [TIMER_BITS-1:0] tick_inc;
  logic [SPEED_W-1:0]    lo, lim;
  logic signed [RATE_W-1:0] lim_s;

  iyrc_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  iyrc_yaw u_yaw (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (yaw_start),
    .quat_x_i  (in_i.quat_x),
    .quat_y_i  (in_i.quat_y),
    .quat_z_i  (in_i.quat_z),
    .quat_w_i  (in_i.quat_w),
    .done_o    (yaw_done),
    .heading_o (yaw_heading)
  );

  assign in_ready   = (st_q == ST_IDLE);
  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;
  assign yaw_start  = in_fire && (in_i.opcode == OP_SAMPLE);
  assign out_free   = !out_valid_q || out_o.ready;

  // Timer: compare before the saturating increment
  assign limit    = (phase_q == PH_WAIT) ? cfg.init_timeout : cfg.rotate_timeout;
  assign over     = TMR_CMP_W'(tick_q) > TMR_CMP_W'(limit);
  assign tick_inc = (tick_q != {TIMER_BITS{1'b1}}) ? tick_q + TIMER_BITS'(1) : tick_q;

  // Heading error; a half turn counts as positive
  assign diff     = goal_q - cur_q;
  assign diff_neg = diff[HEAD_W-1] && (diff[HEAD_W-2:0] != '0);
  assign diff_mag = diff_neg ? (~diff + HEAD_W'(1)) : diff;

  // Clamp magnitude; min_speed wins over max_speed
  assign reached = mag_q < HEAD_W'(cfg.tolerance);
  assign lo      = (mag_q < HEAD_W'(cfg.max_speed)) ? mag_q[SPEED_W-1:0] : cfg.max_speed;
  assign lim     = (lo < cfg.min_speed) ? cfg.min_speed : lo;
  assign lim_s   = signed'(RATE_W'(lim));

  // Sequencer
  always_comb begin
    st_d         = st_q;
    phase_d      = phase_q;
    cur_d        = cur_q;
    goal_d       = goal_q;
    tick_d       = tick_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    res_rate_d   = res_rate_q;
    res_status_d = res_status_q;
    out_rate_d   = out_rate_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          st_d = (in_i.opcode == OP_SAMPLE) ? ST_YAW : ST_TICK;
        end
      end
      ST_YAW: begin
        if (yaw_done) begin
          cur_d = yaw_heading;
          if (phase_q == PH_WAIT) begin
            goal_d  = yaw_heading + cfg.target_delta;
            phase_d = PH_ROTATE;
            tick_d  = '0;
          end
          st_d = ST_IDLE;
        end
      end
      ST_TICK: begin
        st_d = ST_IDLE;
        if (phase_q == PH_WAIT || phase_q == PH_ROTATE) begin
          tick_d = tick_inc;
          if (over) begin
            phase_d      = PH_DONE;
            res_rate_d   = '0;
            res_status_d = (phase_q == PH_WAIT) ? STAT_INIT_TO : STAT_ROT_TO;
            st_d         = ST_EMIT;
          end else if (phase_q == PH_ROTATE) begin
            mag_d = diff_mag;
            neg_d = diff_neg;
            st_d  = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (reached) begin
          phase_d      = PH_DONE;
          res_rate_d   = '0;
          res_status_d = STAT_REACHED;
        end else begin
          res_rate_d   = neg_q ? -lim_s : lim_s;
          res_status_d = STAT_DRIVE;
        end
        st_d = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_rate_d   = res_rate_q;
          out_status_d = res_status_q;
          st_d         = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      phase_q     <= PH_WAIT;
      cur_q       <= '0;
      goal_q      <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      cur_q       <= cur_d;
      goal_q      <= goal_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q        <= mag_d;
    neg_q        <= neg_d;
    res_rate_q   <= res_rate_d;
    res_status_q <= res_status_d;
    out_rate_q   <= out_rate_d;
    out_status_q <= out_status_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.angular_rate = out_rate_q;
  assign out_o.status       = out_status_q;

  // A pending stop leaves the controller finished
  a_stop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT && res_status_q != STAT_DRIVE) |-> (phase_q == PH_DONE))
    else $error("stop pending while still active");

  // Every stop result commands zero rate
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != STAT_DRIVE) |-> (out_rate_q == '0))
    else $error("stop result with nonzero rate");

  // The yaw unit finishes only while a sample is in flight
  a_yaw_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    yaw_done |-> (st_q == ST_YAW))
    else $error("yaw unit finished outside a sample");

endmodule
